FILE: src/bls_pkg.sv
// Package for the bounded LIFO stack unit.
// Holds the request/response payload types, operation and status codes
// and the controller state type. No dependencies.
`default_nettype none

package bls_pkg;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_SHOW = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LIST
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic               last;
   } rsp_type;

endpackage : bls_pkg

`default_nettype wire

FILE: src/bls_rsp_reg.sv
// One-entry response register between the stack controller and the
// response channel. Depends on bls_pkg for the response type.
`default_nettype none

module bls_rsp_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire bls_pkg::rsp_type load_data,
   output logic                 free,
   output logic                 rsp_valid,
   output bls_pkg::rsp_type     rsp_payload,
   input  wire logic            rsp_stall
);
   import bls_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule : bls_rsp_reg

`default_nettype wire

FILE: src/bounded_lifo_stack_unit.sv
// Bounded LIFO stack of signed 32-bit words, top level.
// Depends on bls_pkg and bls_rsp_reg.
//
// Usage:
//   Request channel (req_valid/req_stall/req_payload) carries one operation:
//   push, pop, peek or display. Response channel (rsp_valid/rsp_stall/
//   rsp_payload) returns status, data and last; last marks the final
//   response of a request.
// Operation:
//   Push and every error response are loaded at acceptance, response visible
//   the cycle after acceptance. Pop and peek first do a synchronous read
//   of the word store. Display: one store read per stored word, from the
//   top down. One request is worked on at a time; req_stall is high
//   while a request is in progress or the response register is full and
//   stalled.
// Reset:
//   Synchronous, active high. Clears the fill count and the controller;
//   the word store is not cleared and needs no clearing pass.
// Stall:
//   A stalled response holds in the output register; the controller waits
//   with the store read data held until the register is free.
`default_nettype none

module bounded_lifo_stack_unit #(
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bls_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bls_pkg::rsp_type      rsp_payload
);
   import bls_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [31:0] mem [DEPTH];

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic signed [31:0] rd_data_ff;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic               load;
   rsp_type            load_data;
   logic               out_free;
   logic               accept;
   logic               full;
   logic               empty;
   logic [CW-1:0]      cnt_dec;
   logic [AW-1:0]      top_addr;
   logic [AW-1:0]      ptr_dec;

   bls_rsp_reg u_rsp (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_data   (load_data),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = (cnt_ff == CW'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign cnt_dec   = cnt_ff - CW'(1);
   assign top_addr  = cnt_dec[AW-1:0];
   assign ptr_dec   = ptr_ff - AW'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff;
      wr_en     = 1'b0;
      load      = 1'b0;
      load_data = '{status: STATUS_OK, data: '0, last: 1'b1};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.operation) inside
                  OP_PUSH: begin
                     load = 1'b1;
                     if (full) begin
                        load_data.status = STATUS_OVERFLOW;
                     end else begin
                        wr_en          = 1'b1;
                        cnt_in         = cnt_ff + CW'(1);
                        load_data.data = req_payload.value;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (empty) begin
                        load             = 1'b1;
                        load_data.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        state_in = ST_READ;
                        if (req_payload.operation == OP_POP) begin
                           cnt_in = cnt_dec;
                        end
                     end
                  end
                  default: begin
                     if (empty) begin
                        load             = 1'b1;
                        load_data.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        ptr_in   = top_addr;
                        state_in = ST_LIST;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               load           = 1'b1;
               load_data.data = rd_data_ff;
               state_in       = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               load           = 1'b1;
               load_data.data = rd_data_ff;
               load_data.last = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in  = ptr_dec;
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   // word store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[AW-1:0]] <= req_payload.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule : bounded_lifo_stack_unit

`default_nettype wire

FILE: src/bls_checker.sv
// Port-level checks for the bounded LIFO stack unit, bound to the top level.
// Depends on bls_pkg and bounded_lifo_stack_unit.
`default_nettype none

module bls_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire bls_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bls_pkg::rsp_type rsp_payload
);
   import bls_pkg::*;

   // no response straight out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // a push always answers in the next cycle with a single response
   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.operation == OP_PUSH
      |=> rsp_valid && rsp_payload.last)
      else $error("push response missing");

   // no new request while a display listing is still running
   a_list_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last |-> req_stall)
      else $error("request taken during listing");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK
      |-> rsp_payload.data == '0 && rsp_payload.last)
      else $error("error response carries data");

endmodule : bls_checker

bind bounded_lifo_stack_unit bls_checker u_bls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
